@@ hw/rtl/i2cbs_pkg.sv @@
// shared types, phase codes and register indexes for the i2c master bit sequencer
// no dependencies
package i2cbs_pkg;

	// sequencer phases
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_S1   = 5'd1;
	localparam logic [4:0] PH_S2   = 5'd2;
	localparam logic [4:0] PH_P1   = 5'd3;
	localparam logic [4:0] PH_P2   = 5'd4;
	localparam logic [4:0] PH_A1   = 5'd5;
	localparam logic [4:0] PH_A2   = 5'd6;
	localparam logic [4:0] PH_A3   = 5'd7;
	localparam logic [4:0] PH_W1   = 5'd8;
	localparam logic [4:0] PH_W2   = 5'd9;
	localparam logic [4:0] PH_W3   = 5'd10;
	localparam logic [4:0] PH_R1   = 5'd11;
	localparam logic [4:0] PH_R2   = 5'd12;
	localparam logic [4:0] PH_K1   = 5'd13;
	localparam logic [4:0] PH_K2   = 5'd14;

	// operation codes
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_WACK  = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	// configuration register indexes
	localparam logic REG_TICKS_PER_US = 1'b0;
	localparam logic REG_ACK_TIMEOUT  = 1'b1;

	// register reset values
	localparam logic [15:0] TICKS_PER_US_RST = 16'd40;
	localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;

	// bits per byte
	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_sample;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive_enable;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

	typedef struct packed {
		logic [4:0]  phase;
		logic [7:0]  shift_byte;
		logic [3:0]  bit_count;
		logic [18:0] delay_count;
		logic [7:0]  ack_wait_count;
		logic        ack_choice;
		logic        scl;
		logic        drv;
		logic        lvl;
		logic        ack_fail;
		logic [7:0]  rx_byte;
	} state_t;

	// sequencer state after reset: idle, scl high, sda released high
	localparam state_t STATE_RST = '{phase: PH_IDLE, shift_byte: 8'd0, bit_count: 4'd0,
		delay_count: 19'd0, ack_wait_count: 8'd0, ack_choice: 1'b0, scl: 1'b1,
		drv: 1'b0, lvl: 1'b1, ack_fail: 1'b0, rx_byte: 8'd0};

endpackage

@@ hw/rtl/i2c_master_bit_sequencer.sv @@
// i2c master bit sequencer: an accepted item waits in the input register until the
// result register is free, then moves into it and is shown as the result
// throughput one item per cycle unless the output stalls; an input register and a
// result register around a single pass of the tick logic in i2cbs_step
// reset is asynchronous: lines at scl high with sda released high, sequencer idle,
// registers back to 40 ticks per microsecond and a timeout of 250
module i2c_master_bit_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  i2cbs_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output i2cbs_pkg::res_t   res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);

	i2cbs_pkg::cmd_t   cmd_s1;
	logic              valid_s1;
	i2cbs_pkg::state_t state_q;
	i2cbs_pkg::state_t state_next;
	i2cbs_pkg::res_t   res_next;
	i2cbs_pkg::res_t   res_q;
	logic              res_valid_q;
	logic [15:0]       ticks_per_us_q;
	logic [7:0]        ack_timeout_q;
	logic              advance;

	// handshake: move the held item on whenever the result register is free
	assign advance = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q <= i2cbs_pkg::TICKS_PER_US_RST;
			ack_timeout_q <= i2cbs_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == i2cbs_pkg::REG_TICKS_PER_US) begin
				ticks_per_us_q <= cfg_data;
			end else begin
				ack_timeout_q <= cfg_data[7:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	i2cbs_step u_step (
		.st           (state_q),
		.cmd          (cmd_s1),
		.ticks_per_us (ticks_per_us_q),
		.ack_timeout  (ack_timeout_q),
		.st_next      (state_next),
		.res          (res_next)
	);

	// sequencer state, stepped once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cbs_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

endmodule

@@ hw/rtl/i2cbs_step.sv @@
// next-state and result logic for one tick of the i2c master bit sequencer
// depends on i2cbs_pkg
module i2cbs_step (
	input  i2cbs_pkg::state_t st,
	input  i2cbs_pkg::cmd_t   cmd,
	input  logic [15:0]       ticks_per_us,
	input  logic [7:0]        ack_timeout,
	output i2cbs_pkg::state_t st_next,
	output i2cbs_pkg::res_t   res
);

	logic [15:0] tick_unit;
	logic [18:0] dly1, dly2, dly4;
	logic [18:0] dc;
	logic [3:0]  bc;
	logic        done;

	// phase lengths of one, two and four microseconds
	assign tick_unit = (ticks_per_us == 16'd0) ? 16'd1 : ticks_per_us;
	assign dly1 = {3'b000, tick_unit};
	assign dly2 = {2'b00, tick_unit, 1'b0};
	assign dly4 = {1'b0, tick_unit, 2'b00};
	assign dc = (st.delay_count != 19'd0) ? st.delay_count - 19'd1 : 19'd0;
	assign bc = st.bit_count + 4'd1;

	// phase sequencing
	always_comb begin
		st_next = st;
		done = 1'b0;
		if (st.phase == i2cbs_pkg::PH_IDLE) begin
			case (cmd.operation)
				i2cbs_pkg::OP_START: begin
					st_next.phase = i2cbs_pkg::PH_S1;
					st_next.delay_count = dly4;
					st_next.scl = 1'b1;
					st_next.drv = 1'b1;
					st_next.lvl = 1'b1;
				end
				i2cbs_pkg::OP_STOP: begin
					st_next.phase = i2cbs_pkg::PH_P1;
					st_next.delay_count = dly4;
					st_next.scl = 1'b0;
					st_next.drv = 1'b1;
					st_next.lvl = 1'b0;
				end
				i2cbs_pkg::OP_WRITE: begin
					st_next.shift_byte = cmd.write_data;
					st_next.bit_count = 4'd0;
					st_next.phase = i2cbs_pkg::PH_W1;
					st_next.delay_count = dly2;
					st_next.scl = 1'b0;
					st_next.drv = 1'b1;
					st_next.lvl = cmd.write_data[7];
				end
				i2cbs_pkg::OP_WACK: begin
					st_next.ack_fail = 1'b0;
					st_next.ack_wait_count = 8'd0;
					st_next.phase = i2cbs_pkg::PH_A1;
					st_next.delay_count = dly1;
					st_next.drv = 1'b0;
					st_next.lvl = 1'b1;
				end
				i2cbs_pkg::OP_READ: begin
					st_next.ack_choice = cmd.send_ack;
					st_next.bit_count = 4'd0;
					st_next.shift_byte = 8'd0;
					st_next.phase = i2cbs_pkg::PH_R1;
					st_next.delay_count = dly2;
					st_next.scl = 1'b0;
					st_next.drv = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (st.phase == i2cbs_pkg::PH_A3) begin
			// acknowledge polling
			if (!cmd.sda_sample) begin
				st_next.scl = 1'b0;
				st_next.phase = i2cbs_pkg::PH_IDLE;
				done = 1'b1;
			end else if (st.ack_wait_count == ack_timeout) begin
				st_next.ack_fail = 1'b1;
				st_next.phase = i2cbs_pkg::PH_P1;
				st_next.delay_count = dly4;
				st_next.scl = 1'b0;
				st_next.drv = 1'b1;
				st_next.lvl = 1'b0;
			end else begin
				st_next.ack_wait_count = st.ack_wait_count + 8'd1;
			end
		end else begin
			st_next.delay_count = dc;
			if (dc == 19'd0) begin
				case (st.phase)
					i2cbs_pkg::PH_S1: begin
						st_next.phase = i2cbs_pkg::PH_S2;
						st_next.delay_count = dly4;
						st_next.scl = 1'b1;
						st_next.drv = 1'b1;
						st_next.lvl = 1'b0;
					end
					i2cbs_pkg::PH_S2, i2cbs_pkg::PH_K2: begin
						st_next.scl = 1'b0;
						st_next.phase = i2cbs_pkg::PH_IDLE;
						done = 1'b1;
					end
					i2cbs_pkg::PH_P1: begin
						st_next.phase = i2cbs_pkg::PH_P2;
						st_next.delay_count = dly4;
						st_next.scl = 1'b1;
						st_next.drv = 1'b1;
						st_next.lvl = 1'b1;
					end
					i2cbs_pkg::PH_P2: begin
						st_next.phase = i2cbs_pkg::PH_IDLE;
						done = 1'b1;
					end
					i2cbs_pkg::PH_A1: begin
						st_next.phase = i2cbs_pkg::PH_A2;
						st_next.delay_count = dly1;
						st_next.scl = 1'b1;
						st_next.drv = 1'b0;
						st_next.lvl = 1'b1;
					end
					i2cbs_pkg::PH_A2: begin
						st_next.phase = i2cbs_pkg::PH_A3;
						st_next.ack_wait_count = 8'd0;
					end
					i2cbs_pkg::PH_W1: begin
						st_next.phase = i2cbs_pkg::PH_W2;
						st_next.delay_count = dly2;
						st_next.scl = 1'b1;
						st_next.drv = 1'b1;
					end
					i2cbs_pkg::PH_W2: begin
						st_next.phase = i2cbs_pkg::PH_W3;
						st_next.delay_count = dly2;
						st_next.scl = 1'b0;
						st_next.drv = 1'b1;
					end
					i2cbs_pkg::PH_W3: begin
						st_next.bit_count = bc;
						if (bc >= i2cbs_pkg::BYTE_BITS) begin
							st_next.scl = 1'b0;
							st_next.phase = i2cbs_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
							st_next.phase = i2cbs_pkg::PH_W1;
							st_next.delay_count = dly2;
							st_next.scl = 1'b0;
							st_next.drv = 1'b1;
							st_next.lvl = st.shift_byte[6];
						end
					end
					i2cbs_pkg::PH_R1: begin
						// sample sda as scl rises
						st_next.phase = i2cbs_pkg::PH_R2;
						st_next.delay_count = dly1;
						st_next.scl = 1'b1;
						st_next.drv = 1'b0;
						st_next.shift_byte = {st.shift_byte[6:0], cmd.sda_sample};
					end
					i2cbs_pkg::PH_R2: begin
						st_next.bit_count = bc;
						st_next.delay_count = dly2;
						st_next.scl = 1'b0;
						if (bc >= i2cbs_pkg::BYTE_BITS) begin
							st_next.rx_byte = st.shift_byte;
							st_next.phase = i2cbs_pkg::PH_K1;
							st_next.drv = 1'b1;
							st_next.lvl = !st.ack_choice;
						end else begin
							st_next.phase = i2cbs_pkg::PH_R1;
							st_next.drv = 1'b0;
						end
					end
					i2cbs_pkg::PH_K1: begin
						st_next.phase = i2cbs_pkg::PH_K2;
						st_next.delay_count = dly2;
						st_next.scl = 1'b1;
						st_next.drv = 1'b1;
					end
					default: begin
						st_next.phase = i2cbs_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	// result shows the lines after this tick
	assign res.scl_level = st_next.scl;
	assign res.sda_drive_enable = st_next.drv;
	assign res.sda_level = st_next.lvl;
	assign res.busy_res = (st_next.phase != i2cbs_pkg::PH_IDLE);
	assign res.done_res = done;
	assign res.read_data = st_next.rx_byte;
	assign res.ack_failed = st_next.ack_fail;

endmodule

@@ hw/rtl/i2cbs_checker.sv @@
// port-level checks for the i2c master bit sequencer, bound to the top level
// depends on i2cbs_pkg and i2c_master_bit_sequencer
module i2cbs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_ready,
	input i2cbs_pkg::res_t res,
	input logic            res_valid,
	input logic            res_ready
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// a finished sequence never reports busy on the same tick
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.done_res && res.busy_res))
		else $error("done and busy together");

	// input side is open whenever the output side is not stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || res_ready |-> cmd_ready)
		else $error("input blocked without output stall");

	// an accepted item always yields a result when output drains at acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (!res_valid || res_ready) |=> ##1 res_valid)
		else $error("result missing after accepted item");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.res       (res),
	.res_valid (res_valid),
	.res_ready (res_ready)
);

@@ test/tb_i2c_master_bit_sequencer.sv @@
// self-checking testbench for the i2c master bit sequencer: a tick-level line predictor,
// a directed table at one tick per microsecond, then random bus transfers over several timings
// depends on i2cbs_pkg and i2c_master_bit_sequencer
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer;

	localparam int unsigned LATENCY   = 2;
	localparam int unsigned IDLE_MAX  = 2000;
	localparam int unsigned PRINT_MAX = 50;

	// operation codes with no command behind them
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	// how sda_sample is driven while a command runs out
	localparam logic [1:0] SDA_LOW   = 2'd0;
	localparam logic [1:0] SDA_HIGH  = 2'd1;
	localparam logic [1:0] SDA_RAND  = 2'd2;
	localparam logic [1:0] SDA_NOACK = 2'd3;

	// line states readable straight off the behaviour
	localparam i2cbs_pkg::res_t RES_IDLE = '{scl_level: 1'b1, sda_drive_enable: 1'b0,
		sda_level: 1'b1, busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00, ack_failed: 1'b0};
	localparam i2cbs_pkg::res_t RES_START = '{scl_level: 1'b1, sda_drive_enable: 1'b1,
		sda_level: 1'b1, busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, ack_failed: 1'b0};

	typedef struct packed {
		i2cbs_pkg::cmd_t c;
		logic [1:0]      sda_mode;
		logic            noisy;
		logic            typed;
		i2cbs_pkg::res_t want;
	} plan_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_ready;
	i2cbs_pkg::cmd_t cmd = '0;
	logic            res_valid;
	logic            res_ready = 1'b0;
	i2cbs_pkg::res_t res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic            cfg_index = 1'b0;
	logic [15:0]     cfg_data = 16'h0000;

	// predicted sequencer state and registers
	logic [4:0]  sq_phase = i2cbs_pkg::PH_IDLE;
	logic [7:0]  sq_shift = 8'h00;
	logic [3:0]  sq_bits = 4'd0;
	logic [18:0] sq_delay = 19'd0;
	logic [7:0]  sq_polls = 8'h00;
	logic        sq_ack_pick = 1'b0;
	logic        sq_scl = 1'b1;
	logic        sq_drv = 1'b0;
	logic        sq_lvl = 1'b1;
	logic        sq_ack_fail = 1'b0;
	logic [7:0]  sq_rx = 8'h00;
	logic        sq_done = 1'b0;
	logic [15:0] sq_ticks = i2cbs_pkg::TICKS_PER_US_RST;
	logic [7:0]  sq_timeout = i2cbs_pkg::ACK_TIMEOUT_RST;

	i2cbs_pkg::res_t want_lines[$];
	int unsigned     n_errors = 0;
	int unsigned     n_sent = 0;
	int unsigned     idle_cycles = 0;
	int unsigned     tx_quiet = 0;
	int unsigned     rx_quiet = 0;
	int unsigned     rx_stall = 0;
	bit              no_idle = 1'b0;

	// directed table, run at one tick per microsecond and the reset timeout
	plan_row_t plan [16] = '{
		'{'{i2cbs_pkg::OP_NONE,  8'h00, 1'b0, 1'b0}, SDA_LOW,  1'b0, 1'b1, RES_IDLE},
		'{'{OP_RSVD6,            8'hFF, 1'b1, 1'b1}, SDA_LOW,  1'b0, 1'b1, RES_IDLE},
		'{'{OP_RSVD7,            8'h5A, 1'b0, 1'b1}, SDA_LOW,  1'b0, 1'b1, RES_IDLE},
		'{'{i2cbs_pkg::OP_START, 8'h00, 1'b0, 1'b0}, SDA_RAND, 1'b0, 1'b1, RES_START},
		'{'{i2cbs_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0}, SDA_HIGH, 1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WACK,  8'h00, 1'b0, 1'b1}, SDA_LOW,  1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WRITE, 8'h00, 1'b1, 1'b1}, SDA_RAND, 1'b1, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WACK,  8'hFF, 1'b1, 1'b0}, SDA_HIGH, 1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_START, 8'hFF, 1'b1, 1'b1}, SDA_RAND, 1'b1, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b0}, SDA_RAND, 1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WACK,  8'h00, 1'b0, 1'b0}, SDA_LOW,  1'b1, 1'b0, '0},
		'{'{i2cbs_pkg::OP_READ,  8'h00, 1'b1, 1'b0}, SDA_HIGH, 1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_READ,  8'hFF, 1'b0, 1'b1}, SDA_LOW,  1'b1, 1'b0, '0},
		'{'{i2cbs_pkg::OP_STOP,  8'h3C, 1'b1, 1'b0}, SDA_RAND, 1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_WACK,  8'h00, 1'b0, 1'b0}, SDA_LOW,  1'b0, 1'b0, '0},
		'{'{i2cbs_pkg::OP_READ,  8'hC3, 1'b1, 1'b0}, SDA_RAND, 1'b1, 1'b0, '0}
	};

	i2c_master_bit_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// phase entry: load the delay and set the three line registers
	function automatic void enter_phase(input logic [4:0] nxt, input int unsigned units,
			input logic s, input logic d, input logic l);
		int unsigned t;
		t = (sq_ticks == 16'd0) ? 1 : sq_ticks;
		sq_phase = nxt;
		sq_delay = 19'(units * t);
		sq_scl = s;
		sq_drv = d;
		sq_lvl = l;
	endfunction

	function automatic void close_seq(input logic s);
		sq_scl = s;
		sq_phase = i2cbs_pkg::PH_IDLE;
		sq_done = 1'b1;
	endfunction

	// one tick of the sequencer: new state and the lines after it
	task automatic sequencer_tick(input i2cbs_pkg::cmd_t c, output i2cbs_pkg::res_t r);
		sq_done = 1'b0;
		if (sq_phase == i2cbs_pkg::PH_IDLE) begin
			case (c.operation)
				i2cbs_pkg::OP_START: enter_phase(i2cbs_pkg::PH_S1, 4, 1'b1, 1'b1, 1'b1);
				i2cbs_pkg::OP_STOP:  enter_phase(i2cbs_pkg::PH_P1, 4, 1'b0, 1'b1, 1'b0);
				i2cbs_pkg::OP_WRITE: begin
					sq_shift = c.write_data;
					sq_bits = 4'd0;
					enter_phase(i2cbs_pkg::PH_W1, 2, 1'b0, 1'b1, c.write_data[7]);
				end
				i2cbs_pkg::OP_WACK: begin
					sq_ack_fail = 1'b0;
					sq_polls = 8'h00;
					enter_phase(i2cbs_pkg::PH_A1, 1, sq_scl, 1'b0, 1'b1);
				end
				i2cbs_pkg::OP_READ: begin
					sq_ack_pick = c.send_ack;
					sq_bits = 4'd0;
					sq_shift = 8'h00;
					enter_phase(i2cbs_pkg::PH_R1, 2, 1'b0, 1'b0, sq_lvl);
				end
				default: ;
			endcase
		end else if (sq_phase == i2cbs_pkg::PH_A3) begin
			// acknowledge polling, a timeout turns into a full stop
			if (!c.sda_sample) begin
				close_seq(1'b0);
			end else if (sq_polls == sq_timeout) begin
				sq_ack_fail = 1'b1;
				enter_phase(i2cbs_pkg::PH_P1, 4, 1'b0, 1'b1, 1'b0);
			end else begin
				sq_polls = sq_polls + 8'd1;
			end
		end else begin
			if (sq_delay != 19'd0)
				sq_delay = sq_delay - 19'd1;
			if (sq_delay == 19'd0) begin
				case (sq_phase)
					i2cbs_pkg::PH_S1: enter_phase(i2cbs_pkg::PH_S2, 4, 1'b1, 1'b1, 1'b0);
					i2cbs_pkg::PH_S2: close_seq(1'b0);
					i2cbs_pkg::PH_P1: enter_phase(i2cbs_pkg::PH_P2, 4, 1'b1, 1'b1, 1'b1);
					i2cbs_pkg::PH_P2: close_seq(sq_scl);
					i2cbs_pkg::PH_A1: enter_phase(i2cbs_pkg::PH_A2, 1, 1'b1, 1'b0, 1'b1);
					i2cbs_pkg::PH_A2: begin
						sq_phase = i2cbs_pkg::PH_A3;
						sq_polls = 8'h00;
					end
					i2cbs_pkg::PH_W1: enter_phase(i2cbs_pkg::PH_W2, 2, 1'b1, 1'b1, sq_lvl);
					i2cbs_pkg::PH_W2: enter_phase(i2cbs_pkg::PH_W3, 2, 1'b0, 1'b1, sq_lvl);
					i2cbs_pkg::PH_W3: begin
						sq_bits = sq_bits + 4'd1;
						if (sq_bits >= i2cbs_pkg::BYTE_BITS) begin
							close_seq(1'b0);
						end else begin
							sq_shift = {sq_shift[6:0], 1'b0};
							enter_phase(i2cbs_pkg::PH_W1, 2, 1'b0, 1'b1, sq_shift[7]);
						end
					end
					i2cbs_pkg::PH_R1: begin
						enter_phase(i2cbs_pkg::PH_R2, 1, 1'b1, 1'b0, sq_lvl);
						sq_shift = {sq_shift[6:0], c.sda_sample};
					end
					i2cbs_pkg::PH_R2: begin
						sq_bits = sq_bits + 4'd1;
						if (sq_bits >= i2cbs_pkg::BYTE_BITS) begin
							sq_rx = sq_shift;
							enter_phase(i2cbs_pkg::PH_K1, 2, 1'b0, 1'b1, ~sq_ack_pick);
						end else begin
							enter_phase(i2cbs_pkg::PH_R1, 2, 1'b0, 1'b0, sq_lvl);
						end
					end
					i2cbs_pkg::PH_K1: enter_phase(i2cbs_pkg::PH_K2, 2, 1'b1, 1'b1, sq_lvl);
					i2cbs_pkg::PH_K2: close_seq(1'b0);
					default: sq_phase = i2cbs_pkg::PH_IDLE;
				endcase
			end
		end
		r.scl_level = sq_scl;
		r.sda_drive_enable = sq_drv;
		r.sda_level = sq_lvl;
		r.busy_res = (sq_phase != i2cbs_pkg::PH_IDLE);
		r.done_res = sq_done;
		r.read_data = sq_rx;
		r.ack_failed = sq_ack_fail;
	endtask

	// gap length: mostly none or short, a few long, with quiet stretches
	function automatic int unsigned pick_gap(inout int unsigned quiet);
		int unsigned r;
		if (no_idle)
			return 0;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 3) begin
			quiet = $urandom_range(80, 20);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 13);
	endfunction

	function automatic i2cbs_pkg::cmd_t mk_cmd(input logic [2:0] op);
		i2cbs_pkg::cmd_t c;
		c.operation = op;
		c.write_data = 8'($urandom);
		c.send_ack = 1'($urandom);
		c.sda_sample = 1'($urandom);
		return c;
	endfunction

	function automatic void report(input string field, input int unsigned want,
			input int unsigned got);
		if (n_errors < PRINT_MAX)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		n_errors++;
	endfunction

	// one item onto the command channel, predicted at acceptance
	task automatic send_cmd(input i2cbs_pkg::cmd_t c, input logic typed,
			input i2cbs_pkg::res_t want);
		i2cbs_pkg::res_t pred;
		int unsigned n;
		n = pick_gap(tx_quiet);
		if (n > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		sequencer_tick(c, pred);
		want_lines.push_back(typed ? want : pred);
		n_sent++;
	endtask

	// a command followed by ticks until the sequence has finished
	task automatic issue(input i2cbs_pkg::cmd_t c, input logic [1:0] sda_mode,
			input logic noisy, input logic typed, input i2cbs_pkg::res_t want);
		i2cbs_pkg::cmd_t t;
		send_cmd(c, typed, want);
		while (sq_phase != i2cbs_pkg::PH_IDLE) begin
			t = mk_cmd(i2cbs_pkg::OP_NONE);
			// commands while busy should be ignored
			if (noisy && $urandom_range(7, 0) == 0)
				t.operation = 3'($urandom_range(7, 0));
			case (sda_mode)
				SDA_LOW:   t.sda_sample = 1'b0;
				SDA_HIGH:  t.sda_sample = 1'b1;
				SDA_NOACK: if (sq_phase == i2cbs_pkg::PH_A3) t.sda_sample = 1'b1;
				default:   if (sq_phase == i2cbs_pkg::PH_A3)
					t.sda_sample = ($urandom_range(2, 0) != 0);
			endcase
			send_cmd(t, 1'b0, '0);
		end
	endtask

	// well-formed bus transfer most of the time, a lone random command otherwise
	task automatic rand_transfer();
		int unsigned n;
		if ($urandom_range(99, 0) < 85) begin
			issue(mk_cmd(i2cbs_pkg::OP_START), SDA_RAND, 1'($urandom), 1'b0, '0);
			issue(mk_cmd(i2cbs_pkg::OP_WRITE), SDA_RAND, 1'($urandom), 1'b0, '0);
			issue(mk_cmd(i2cbs_pkg::OP_WACK),
				($urandom_range(4, 0) == 0) ? SDA_NOACK : SDA_RAND, 1'($urandom), 1'b0, '0);
			n = $urandom_range(3, 1);
			while (n > 0 && !sq_ack_fail) begin
				if ($urandom_range(1, 0) == 0) begin
					issue(mk_cmd(i2cbs_pkg::OP_WRITE), SDA_RAND, 1'($urandom), 1'b0, '0);
					issue(mk_cmd(i2cbs_pkg::OP_WACK),
						($urandom_range(4, 0) == 0) ? SDA_NOACK : SDA_RAND,
						1'($urandom), 1'b0, '0);
				end else begin
					issue(mk_cmd(i2cbs_pkg::OP_READ), SDA_RAND, 1'($urandom), 1'b0, '0);
				end
				n--;
			end
			if (!sq_ack_fail)
				issue(mk_cmd(i2cbs_pkg::OP_STOP), SDA_RAND, 1'($urandom), 1'b0, '0);
		end else begin
			issue(mk_cmd(3'($urandom_range(7, 0))), SDA_RAND, 1'b1, 1'b0, '0);
		end
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned start;
		start = n_sent;
		while (n_sent - start < budget)
			rand_transfer();
	endtask

	// stop sending and let every expected line arrive
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (want_lines.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [15:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == i2cbs_pkg::REG_TICKS_PER_US)
			sq_ticks = data;
		else
			sq_timeout = data[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver side stalls
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			rx_stall = pick_gap(rx_quiet);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (want_lines.size() == 0) begin
				if (n_errors < PRINT_MAX)
					$display("%0t: unexpected result item, actual %0h", $time, res);
				n_errors++;
			end else begin
				i2cbs_pkg::res_t w;
				w = want_lines.pop_front();
				if (res.scl_level !== w.scl_level)
					report("scl_level", w.scl_level, res.scl_level);
				if (res.sda_drive_enable !== w.sda_drive_enable)
					report("sda_drive_enable", w.sda_drive_enable, res.sda_drive_enable);
				if (res.sda_level !== w.sda_level)
					report("sda_level", w.sda_level, res.sda_level);
				if (res.busy_res !== w.busy_res)
					report("busy_res", w.busy_res, res.busy_res);
				if (res.done_res !== w.done_res)
					report("done_res", w.done_res, res.done_res);
				if (res.read_data !== w.read_data)
					report("read_data", w.read_data, res.read_data);
				if (res.ack_failed !== w.ack_failed)
					report("ack_failed", w.ack_failed, res.ack_failed);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_MAX) begin
				$display("[i2c_master_bit_sequencer] ERROR");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// short phases keep the directed transfers brief, timeout left at reset
		cfg_write(i2cbs_pkg::REG_TICKS_PER_US, 16'd1);
		foreach (plan[i])
			issue(plan[i].c, plan[i].sda_mode, plan[i].noisy, plan[i].typed, plan[i].want);

		cfg_write(i2cbs_pkg::REG_ACK_TIMEOUT, 16'h0000);
		run_random(100);

		// zero ticks per microsecond runs as one
		cfg_write(i2cbs_pkg::REG_TICKS_PER_US, 16'd0);
		cfg_write(i2cbs_pkg::REG_ACK_TIMEOUT, 16'hFF05);
		run_random(80);

		cfg_write(i2cbs_pkg::REG_TICKS_PER_US, 16'd2);
		cfg_write(i2cbs_pkg::REG_ACK_TIMEOUT, 16'h00FF);
		run_random(40);

		cfg_write(i2cbs_pkg::REG_TICKS_PER_US, 16'($urandom_range(2, 1)));
		cfg_write(i2cbs_pkg::REG_ACK_TIMEOUT, {8'($urandom), 8'($urandom_range(12, 0))});
		run_random(40);

		// back to back with no idling on either side
		cfg_write(i2cbs_pkg::REG_TICKS_PER_US, 16'd1);
		cfg_write(i2cbs_pkg::REG_ACK_TIMEOUT, 16'hFF00);
		no_idle = 1'b1;
		issue(mk_cmd(i2cbs_pkg::OP_START), SDA_RAND, 1'b1, 1'b0, '0);
		issue(mk_cmd(i2cbs_pkg::OP_WACK), SDA_LOW, 1'b1, 1'b0, '0);
		issue(mk_cmd(i2cbs_pkg::OP_STOP), SDA_RAND, 1'b1, 1'b0, '0);
		settle();
		no_idle = 1'b0;

		if (n_errors == 0 && want_lines.size() == 0)
			$display("[i2c_master_bit_sequencer] OK");
		else
			$display("[i2c_master_bit_sequencer] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/i2cbs_pkg.sv
hw/rtl/i2cbs_step.sv
hw/rtl/i2c_master_bit_sequencer.sv
hw/rtl/i2cbs_checker.sv
test/tb_i2c_master_bit_sequencer.sv
